FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the sorted key/value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/skvt_pkg.sv
// Package with constants and types of the sorted key/value table.
package skvt_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 24;
   localparam int VALUE_BITS = 32;
   // Slot index wide enough to hold CAPACITY itself (one past the end).
   localparam int SLOT_BITS  = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_GET    = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] result_value;
      logic                  found;
      logic                  table_full;
   } rsp_payload_type;

   // Contents of one slot.
   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic                  used;
   } entry_type;

   // What a cell does at the next clock edge.
   typedef enum logic [2:0] {
      CELL_HOLD        = 3'd0,
      CELL_LOAD        = 3'd1,
      CELL_WRITE_VALUE = 3'd2,
      CELL_SHIFT_UP    = 3'd3,
      CELL_SHIFT_DOWN  = 3'd4
   } cell_op_type;

   // Compare results that a cell reports to the control logic.
   typedef struct packed {
      logic lt;       // used and key below the request key
      logic eq;       // used and key equal to the request key
      logic cur_hit;  // under the cursor, used and key not above the cursor key
   } cell_stat_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

endpackage

FILE: hw/rtl/skvt_cell.sv
// One slot of the sorted table: stores an entry, compares it and shifts with its neighbors.
module skvt_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  skvt_pkg::cell_op_type          cell_op,
   input  logic                           rd_sel,
   input  logic                           cur_sel,
   input  skvt_pkg::req_payload_type      req,
   input  logic [skvt_pkg::KEY_BITS-1:0]  cursor_key,
   input  skvt_pkg::entry_type            lower_entry,
   input  skvt_pkg::entry_type            upper_entry,
   output skvt_pkg::entry_type            entry,
   output skvt_pkg::cell_stat_type        stat,
   output logic [skvt_pkg::VALUE_BITS-1:0] rd_value
);
   import skvt_pkg::*;

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  used_ff;
   entry_type             entry_in;

   always_comb begin
      entry_in = '{key: key_ff, value: value_ff, used: used_ff};
      case (cell_op)
         CELL_HOLD: begin
         end
         CELL_LOAD: begin
            entry_in = '{key: req.key, value: req.value, used: 1'b1};
         end
         CELL_WRITE_VALUE: begin
            entry_in.value = req.value;
         end
         CELL_SHIFT_UP: begin
            entry_in = lower_entry;
         end
         CELL_SHIFT_DOWN: begin
            entry_in = upper_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= entry_in.used;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= entry_in.key;
      value_ff <= entry_in.value;
   end

   assign entry        = '{key: key_ff, value: value_ff, used: used_ff};
   assign stat.lt      = used_ff && (key_ff < req.key);
   assign stat.eq      = used_ff && (key_ff == req.key);
   assign stat.cur_hit = cur_sel && used_ff && (key_ff <= cursor_key);
   assign rd_value     = value_ff & {VALUE_BITS{rd_sel}};

endmodule

FILE: hw/rtl/sorted_key_value_table.sv
// Top level of the sorted key/value table: a chain of slot cells and its control.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_data (op, key, value)
//   rsp_      out        rsp_valid/rsp_stall  rsp_data (result_value, found, table_full)
//
// A request is captured into a register in the idle state; in the execute cycle, every
// cell compares its key in parallel and the whole chain shifts or updates at once.
// The next request is taken in the cycle after the execute cycle.
// The execute cycle waits while an earlier response is still stalled in the output register.
// Reset (synchronous, active high) empties the table, clears the cursor and drops any
// pending response; slot keys and values are not cleared, only their used bits.
module sorted_key_value_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  skvt_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output skvt_pkg::rsp_payload_type rsp_data
);
   import skvt_pkg::*;

   `include "assert_macros.svh"

   // Control state and the captured request.
   state_type             state_ff, state_in;
   req_payload_type       req_ff, req_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;
   logic [SLOT_BITS-1:0]  cursor_slot_ff, cursor_slot_in;
   logic [KEY_BITS-1:0]   cursor_key_ff, cursor_key_in;

   // The key that a next operation compares against: the cursor key advanced by one.
   logic [KEY_BITS-1:0]   cursor_key_next;

   // Per-cell wiring of the chain.
   entry_type             entries       [CAPACITY];
   entry_type             lower_entries [CAPACITY];
   entry_type             upper_entries [CAPACITY];
   cell_op_type           cell_ops      [CAPACITY];
   cell_stat_type         stats         [CAPACITY];
   logic [VALUE_BITS-1:0] rd_values     [CAPACITY];

   logic [CAPACITY-1:0]   lt_vec;
   logic [CAPACITY-1:0]   eq_vec;
   logic [CAPACITY-1:0]   cur_hit_vec;
   logic [CAPACITY-1:0]   prev_lt_vec;
   logic [CAPACITY-1:0]   pos_vec;
   logic [CAPACITY-1:0]   cur_sel_vec;
   logic [CAPACITY-1:0]   rd_sel_vec;
   logic [CAPACITY-1:0]   used_vec;

   logic                  do_exec;
   logic                  hit_any;
   logic                  cur_hit_any;
   logic                  used_last;
   logic                  do_insert;
   logic                  do_remove;
   logic [SLOT_BITS-1:0]  pos_idx;
   logic [VALUE_BITS-1:0] read_value;

   assign cursor_key_next = cursor_key_ff + KEY_BITS'(1);

   // The execute cycle runs once the output register is free or being drained.
   assign do_exec   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The chain of cells. The used slots always form a prefix, so the cells whose keys
   // are below the request key form a prefix as well, and the search position is the
   // first cell that is not below. A cell finds that out from its own flag and its
   // lower neighbor's.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign lower_entries[g] = '0;
         assign prev_lt_vec[g]   = 1'b1;
      end else begin : g_inner
         assign lower_entries[g] = entries[g-1];
         assign prev_lt_vec[g]   = lt_vec[g-1];
      end
      // The top cell takes in an empty slot when the table shifts down.
      if (g == CAPACITY - 1) begin : g_last
         assign upper_entries[g] = '0;
      end else begin : g_below
         assign upper_entries[g] = entries[g+1];
      end

      assign lt_vec[g]      = stats[g].lt;
      assign eq_vec[g]      = stats[g].eq;
      assign cur_hit_vec[g] = stats[g].cur_hit;
      assign used_vec[g]    = entries[g].used;
      assign pos_vec[g]     = prev_lt_vec[g] && !lt_vec[g];
      assign cur_sel_vec[g] = (cursor_slot_ff == SLOT_BITS'(g));
      // Keys are unique, so an equal key can only sit at the search position.
      assign rd_sel_vec[g]  = (req_ff.op == OP_NEXT) ? cur_hit_vec[g] : eq_vec[g];

      always_comb begin
         cell_ops[g] = CELL_HOLD;
         if (do_exec) begin
            case (req_ff.op)
               OP_SET: begin
                  if (eq_vec[g]) begin
                     cell_ops[g] = CELL_WRITE_VALUE;
                  end else if (do_insert && pos_vec[g]) begin
                     cell_ops[g] = CELL_LOAD;
                  end else if (do_insert && !prev_lt_vec[g]) begin
                     // Every cell above the insert position takes its lower neighbor.
                     cell_ops[g] = CELL_SHIFT_UP;
                  end
               end
               OP_REMOVE: begin
                  // The removed cell and every cell above it take the upper neighbor.
                  if (do_remove && !lt_vec[g]) begin
                     cell_ops[g] = CELL_SHIFT_DOWN;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      skvt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_op     (cell_ops[g]),
         .rd_sel      (rd_sel_vec[g]),
         .cur_sel     (cur_sel_vec[g]),
         .req         (req_ff),
         .cursor_key  (cursor_key_next),
         .lower_entry (lower_entries[g]),
         .upper_entry (upper_entries[g]),
         .entry       (entries[g]),
         .stat        (stats[g]),
         .rd_value    (rd_values[g])
      );
   end

   assign hit_any     = |eq_vec;
   assign cur_hit_any = |cur_hit_vec;
   assign used_last   = entries[CAPACITY-1].used;
   // An insert needs a free top slot. When every slot is used and every key is
   // smaller, the top slot is used as well, so that case is refused the same way.
   assign do_insert   = (req_ff.op == OP_SET) && !hit_any && !used_last;
   assign do_remove   = (req_ff.op == OP_REMOVE) && hit_any;

   // Binary search position from the one-hot position; one past the end when every
   // cell is below the request key.
   always_comb begin
      pos_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (pos_vec[i]) begin
            pos_idx = pos_idx | SLOT_BITS'(i);
         end
      end
      if (&lt_vec) begin
         pos_idx = SLOT_BITS'(CAPACITY);
      end
   end

   // At most one cell is selected, so the read is an OR over the masked values.
   always_comb begin
      read_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_value = read_value | rd_values[i];
      end
   end

   // Sequencing, cursor update and response register.
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      cursor_slot_in = cursor_slot_ff;
      cursor_key_in  = cursor_key_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (do_exec) begin
               state_in                 = ST_IDLE;
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = read_value;
               rsp_data_in.found        = |rd_sel_vec;
               rsp_data_in.table_full   = (req_ff.op == OP_SET) && !hit_any && used_last;
               case (req_ff.op)
                  OP_GET: begin
                     // A hit leaves the cursor just past the found entry.
                     cursor_key_in  = req_ff.key;
                     cursor_slot_in = pos_idx + SLOT_BITS'(hit_any);
                  end
                  OP_NEXT: begin
                     cursor_key_in  = cursor_key_next;
                     cursor_slot_in = cursor_slot_ff + SLOT_BITS'(cur_hit_any);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         cursor_slot_ff <= '0;
         cursor_key_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cursor_slot_ff <= cursor_slot_in;
         cursor_key_ff  <= cursor_key_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The used slots stay a prefix of the table.
   `ASSERT_IMPLIES(a_used_prefix, clock, reset, 1'b1, ((used_vec >> 1) & ~used_vec) == '0)
   // Never more than one cell drives the read.
   `ASSERT_IMPLIES(a_one_reader, clock, reset, state_ff == ST_EXEC, $onehot0(rd_sel_vec))
   // A refused insert never reports a found entry, and a miss returns zero.
   `ASSERT_IMPLIES(a_rsp_consistent, clock, reset, rsp_valid_ff,
      !(rsp_data_ff.found && rsp_data_ff.table_full)
      && (rsp_data_ff.found || rsp_data_ff.result_value == '0))
   // An accepted transaction enters the execute state next.
   `ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall, state_ff == ST_EXEC)

endmodule
